// ----- rtl/kms_pkg.sv -----
// Package for the kinematic motion step block.
// Shared command struct, axis and register codes, saturation helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kms_pkg;

   localparam int WORD_W    = 32;
   localparam int REG_W     = 31;
   localparam int DT_W      = 16;
   localparam int AXIS_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = 50;

   localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_ANG  = 2'd2;
   localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_ANG;

   localparam logic [CSR_IDX_W-1:0] CSR_DRAG_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAG_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAG_ANG  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_ANG = 3'd5;

   localparam logic MODE_LOAD = 1'b1;

   typedef struct packed {
      logic              capture;
      logic              load;
      logic              mul_vel;
      logic              upd_vel;
      logic              mul_pos;
      logic              upd_pos;
      logic              publish;
      logic [AXIS_W-1:0] axis;
   } cmd_type;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [34:0] x);
      logic signed [34:0] hi;
      logic signed [34:0] lo;
      hi = 35'sh0_7FFF_FFFF;
      lo = -35'sh0_8000_0000;
      if (x > hi) begin
         sat_word = 32'sh7FFF_FFFF;
      end else if (x < lo) begin
         sat_word = 32'sh8000_0000;
      end else begin
         sat_word = x[WORD_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/kms_datapath.sv -----
// Datapath: state, configuration registers, shared 33x17 multiplier,
// velocity and position update logic. Depends on kms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kms_datapath import kms_pkg::*; (
   input  wire                        clock,
   input  wire                        reset,
   input  cmd_type                    cmd,
   input  wire                        csr_we,
   input  wire  [CSR_IDX_W-1:0]       csr_index,
   input  wire  [WORD_W-1:0]          csr_wdata,
   input  wire                        req_mode,
   input  wire  [DT_W-1:0]            req_step_time,
   input  wire  signed [WORD_W-1:0]   req_accel_x,
   input  wire  signed [WORD_W-1:0]   req_accel_y,
   input  wire  signed [WORD_W-1:0]   req_accel_angular,
   input  wire  signed [WORD_W-1:0]   req_load_pos_x,
   input  wire  signed [WORD_W-1:0]   req_load_pos_y,
   input  wire  signed [WORD_W-1:0]   req_load_heading,
   input  wire  signed [WORD_W-1:0]   req_load_vel_x,
   input  wire  signed [WORD_W-1:0]   req_load_vel_y,
   input  wire  signed [WORD_W-1:0]   req_load_spin,
   output logic signed [WORD_W-1:0]   rsp_pos_x,
   output logic signed [WORD_W-1:0]   rsp_pos_y,
   output logic signed [WORD_W-1:0]   rsp_heading,
   output logic signed [WORD_W-1:0]   rsp_vel_x,
   output logic signed [WORD_W-1:0]   rsp_vel_y,
   output logic signed [WORD_W-1:0]   rsp_spin
);

   logic [REG_W-1:0]         drag_ff  [3];
   logic [REG_W-1:0]         limit_ff [3];
   logic signed [WORD_W-1:0] pos_ff   [3];
   logic signed [WORD_W-1:0] vel_ff   [3];
   logic signed [WORD_W-1:0] acc_ff   [3];
   logic [DT_W-1:0]          dt_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [WORD_W-1:0] nv_ff;
   logic signed [32:0]       sum_ff;

   logic signed [WORD_W-1:0] acc_sel, vel_sel, pos_sel;
   logic [REG_W-1:0]         drag_sel, lim_sel;
   logic signed [32:0]       op_a;
   logic signed [16:0]       op_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] round_acc, round_pos;
   logic signed [34:0]       acc_sum;
   logic signed [WORD_W-1:0] v_acc;
   logic signed [33:0]       drag_t, v_minus, v_plus;
   logic signed [WORD_W-1:0] v_drag, v_base, nv_in;
   logic signed [32:0]       v_wide, lim_wide;
   logic signed [34:0]       pos_sum;
   logic signed [WORD_W-1:0] pos_in;

   always_comb begin
      acc_sel  = acc_ff[cmd.axis];
      vel_sel  = vel_ff[cmd.axis];
      pos_sel  = pos_ff[cmd.axis];
      drag_sel = drag_ff[cmd.axis];
      lim_sel  = limit_ff[cmd.axis];

      if (cmd.mul_pos) begin
         op_a = sum_ff;
      end else if (acc_sel != '0) begin
         op_a = {acc_sel[WORD_W-1], acc_sel};
      end else begin
         op_a = {2'b00, drag_sel};
      end
      op_b    = $signed({1'b0, dt_ff});
      prod_in = PROD_W'(op_a * op_b);

      // acceleration term, round half up
      round_acc = prod_ff + PROD_W'(50'sd32768);
      acc_sum   = 35'(vel_sel) + 35'($signed(round_acc[PROD_W-1:16]));
      v_acc     = sat_word(acc_sum);

      // drag term, truncated and nonnegative
      drag_t  = $signed({3'b000, prod_ff[46:16]});
      v_minus = 34'(vel_sel) - drag_t;
      v_plus  = 34'(vel_sel) + drag_t;
      if (v_minus > 34'sd0) begin
         v_drag = v_minus[WORD_W-1:0];
      end else if (v_plus < 34'sd0) begin
         v_drag = v_plus[WORD_W-1:0];
      end else begin
         v_drag = '0;
      end

      if (acc_sel != '0) begin
         v_base = v_acc;
      end else if (drag_sel != '0) begin
         v_base = v_drag;
      end else begin
         v_base = vel_sel;
      end

      v_wide   = 33'(v_base);
      lim_wide = $signed({2'b00, lim_sel});
      nv_in    = v_base;
      if (v_base != '0 && lim_sel != '0) begin
         if (v_wide > lim_wide) begin
            nv_in = $signed({1'b0, lim_sel});
         end else if (v_wide < -lim_wide) begin
            nv_in = WORD_W'(-lim_wide);
         end
      end

      round_pos = prod_ff + PROD_W'(50'sd65536);
      pos_sum   = 35'(pos_sel) + 35'($signed(round_pos[PROD_W-1:17]));
      pos_in    = sat_word(pos_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            drag_ff[i]  <= '0;
            limit_ff[i] <= '0;
            pos_ff[i]   <= '0;
            vel_ff[i]   <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_DRAG_X:    drag_ff[AXIS_X]    <= csr_wdata[REG_W-1:0];
               CSR_DRAG_Y:    drag_ff[AXIS_Y]    <= csr_wdata[REG_W-1:0];
               CSR_DRAG_ANG:  drag_ff[AXIS_ANG]  <= csr_wdata[REG_W-1:0];
               CSR_LIMIT_X:   limit_ff[AXIS_X]   <= csr_wdata[REG_W-1:0];
               CSR_LIMIT_Y:   limit_ff[AXIS_Y]   <= csr_wdata[REG_W-1:0];
               CSR_LIMIT_ANG: limit_ff[AXIS_ANG] <= csr_wdata[REG_W-1:0];
               default: ;
            endcase
         end
         if (cmd.capture && req_mode == MODE_LOAD) begin
            pos_ff[AXIS_X]   <= req_load_pos_x;
            pos_ff[AXIS_Y]   <= req_load_pos_y;
            pos_ff[AXIS_ANG] <= req_load_heading;
            vel_ff[AXIS_X]   <= req_load_vel_x;
            vel_ff[AXIS_Y]   <= req_load_vel_y;
            vel_ff[AXIS_ANG] <= req_load_spin;
         end else if (cmd.upd_pos) begin
            pos_ff[cmd.axis] <= pos_in;
            vel_ff[cmd.axis] <= nv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dt_ff            <= req_step_time;
         acc_ff[AXIS_X]   <= req_accel_x;
         acc_ff[AXIS_Y]   <= req_accel_y;
         acc_ff[AXIS_ANG] <= req_accel_angular;
      end
      if (cmd.mul_vel || cmd.mul_pos) begin
         prod_ff <= prod_in;
      end
      if (cmd.upd_vel) begin
         nv_ff  <= nv_in;
         sum_ff <= 33'(vel_sel) + 33'(nv_in);
      end
      if (cmd.publish) begin
         rsp_pos_x   <= pos_ff[AXIS_X];
         rsp_pos_y   <= pos_ff[AXIS_Y];
         rsp_heading <= pos_ff[AXIS_ANG];
         rsp_vel_x   <= vel_ff[AXIS_X];
         rsp_vel_y   <= vel_ff[AXIS_Y];
         rsp_spin    <= vel_ff[AXIS_ANG];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/kms_control.sv -----
// Controller: sequences the three axes through multiply and update steps
// and owns the request/response handshakes. Depends on kms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kms_control import kms_pkg::*; (
   input  wire      clock,
   input  wire      reset,
   input  wire      req_valid,
   output logic     req_ready,
   input  wire      req_mode,
   output logic     rsp_valid,
   input  wire      rsp_ready,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_V,
      S_VEL,
      S_MUL_P,
      S_POS,
      S_FINISH
   } state_type;

   state_type         state_ff;
   logic [AXIS_W-1:0] axis_ff;
   logic              rsp_valid_ff;
   logic              out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd         = '0;
      cmd.axis    = axis_ff;
      cmd.capture = req_valid && req_ready;
      cmd.mul_vel = (state_ff == S_MUL_V);
      cmd.upd_vel = (state_ff == S_VEL);
      cmd.mul_pos = (state_ff == S_MUL_P);
      cmd.upd_pos = (state_ff == S_POS);
      cmd.publish = (state_ff == S_FINISH) && out_free;
      cmd.load    = cmd.capture && (req_mode == MODE_LOAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               axis_ff <= AXIS_X;
               if (cmd.capture) begin
                  state_ff <= cmd.load ? S_FINISH : S_MUL_V;
               end
            end
            S_MUL_V: state_ff <= S_VEL;
            S_VEL:   state_ff <= S_MUL_P;
            S_MUL_P: state_ff <= S_POS;
            S_POS: begin
               if (axis_ff == AXIS_LAST) begin
                  state_ff <= S_FINISH;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= S_MUL_V;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      axis_ff <= AXIS_LAST)
      else $error("axis counter out of range");

   a_last_axis_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POS && axis_ff == AXIS_LAST |=> state_ff == S_FINISH)
      else $error("sequence did not finish after last axis");

   a_load_direct: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_FINISH)
      else $error("load request did not go straight to finish");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten while pending");

endmodule

`default_nettype wire

// ----- rtl/kinematic_motion_step_top.sv -----
// Kinematic motion step, top level: ties controller and datapath together.
// Depends on kms_pkg, kms_control, kms_datapath.
//
// Usage:
//   req_*  : one request per tick, valid/ready. req_mode = 1 loads the six
//            state values from the load fields; req_mode = 0 advances the
//            motion state by req_step_time using the accelerations.
//   rsp_*  : one response per request, the state after that request,
//            valid/ready, held in an output register.
//   csr_*  : register writes (drag and speed limit per axis), always ready;
//            write only while no request is in flight.
// Sequence: after a load is accepted the block goes straight to publish; after
//   an advance is accepted, one shared 33x17 multiplier is used twice
//   per axis, with a velocity and a position update step after each, over
//   3 axes, then the result is published once the output register is free.
// Flow: one request at a time; req_ready is high only when idle, so a new
//   request is taken only once the previous one has been published.
// A new request may be accepted while the previous response is still
//   pending; if the receiver stalls, the block holds its result until the
//   output register is free.
// Reset: positions, velocities and the drag and limit registers clear to
//   zero; other registers are not reset; no response is pending.
`timescale 1ns / 1ps
`default_nettype none

module kinematic_motion_step_top import kms_pkg::*; (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire                        req_mode,
   input  wire  [DT_W-1:0]            req_step_time,
   input  wire  signed [WORD_W-1:0]   req_accel_x,
   input  wire  signed [WORD_W-1:0]   req_accel_y,
   input  wire  signed [WORD_W-1:0]   req_accel_angular,
   input  wire  signed [WORD_W-1:0]   req_load_pos_x,
   input  wire  signed [WORD_W-1:0]   req_load_pos_y,
   input  wire  signed [WORD_W-1:0]   req_load_heading,
   input  wire  signed [WORD_W-1:0]   req_load_vel_x,
   input  wire  signed [WORD_W-1:0]   req_load_vel_y,
   input  wire  signed [WORD_W-1:0]   req_load_spin,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic signed [WORD_W-1:0]   rsp_pos_x,
   output logic signed [WORD_W-1:0]   rsp_pos_y,
   output logic signed [WORD_W-1:0]   rsp_heading,
   output logic signed [WORD_W-1:0]   rsp_vel_x,
   output logic signed [WORD_W-1:0]   rsp_vel_y,
   output logic signed [WORD_W-1:0]   rsp_spin,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [CSR_IDX_W-1:0]       csr_index,
   input  wire  [WORD_W-1:0]          csr_wdata
);

   cmd_type cmd;

   assign csr_ready = 1'b1;

   kms_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   kms_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_mode          (req_mode),
      .req_step_time     (req_step_time),
      .req_accel_x       (req_accel_x),
      .req_accel_y       (req_accel_y),
      .req_accel_angular (req_accel_angular),
      .req_load_pos_x    (req_load_pos_x),
      .req_load_pos_y    (req_load_pos_y),
      .req_load_heading  (req_load_heading),
      .req_load_vel_x    (req_load_vel_x),
      .req_load_vel_y    (req_load_vel_y),
      .req_load_spin     (req_load_spin),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_heading       (rsp_heading),
      .rsp_vel_x         (rsp_vel_x),
      .rsp_vel_y         (rsp_vel_y),
      .rsp_spin          (rsp_spin)
   );

endmodule

`default_nettype wire

// ----- tb/kinematic_motion_step_top_test.sv -----
// Self-checking testbench for kinematic_motion_step_top: directed and random
// load/advance requests checked against a fixed-point motion predictor.
// Depends on kms_pkg and the kinematic_motion_step_top RTL.
`timescale 1ns / 1ps

module kinematic_motion_step_top_test import kms_pkg::*;;

   localparam logic MODE_ADVANCE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam int IDLE_PCT = 27;
   localparam int PHASES = 8;
   localparam int PHASE_REQUESTS = 243;

   typedef struct packed {
      logic                     mode;
      logic [DT_W-1:0]          step_time;
      logic signed [WORD_W-1:0] accel_x;
      logic signed [WORD_W-1:0] accel_y;
      logic signed [WORD_W-1:0] accel_angular;
      logic signed [WORD_W-1:0] load_pos_x;
      logic signed [WORD_W-1:0] load_pos_y;
      logic signed [WORD_W-1:0] load_heading;
      logic signed [WORD_W-1:0] load_vel_x;
      logic signed [WORD_W-1:0] load_vel_y;
      logic signed [WORD_W-1:0] load_spin;
   } motion_request_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] heading;
      logic signed [WORD_W-1:0] vel_x;
      logic signed [WORD_W-1:0] vel_y;
      logic signed [WORD_W-1:0] spin;
   } motion_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_mode = 1'b0;
   logic [DT_W-1:0]          req_step_time = '0;
   logic signed [WORD_W-1:0] req_accel_x = '0;
   logic signed [WORD_W-1:0] req_accel_y = '0;
   logic signed [WORD_W-1:0] req_accel_angular = '0;
   logic signed [WORD_W-1:0] req_load_pos_x = '0;
   logic signed [WORD_W-1:0] req_load_pos_y = '0;
   logic signed [WORD_W-1:0] req_load_heading = '0;
   logic signed [WORD_W-1:0] req_load_vel_x = '0;
   logic signed [WORD_W-1:0] req_load_vel_y = '0;
   logic signed [WORD_W-1:0] req_load_spin = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [WORD_W-1:0] rsp_pos_x;
   logic signed [WORD_W-1:0] rsp_pos_y;
   logic signed [WORD_W-1:0] rsp_heading;
   logic signed [WORD_W-1:0] rsp_vel_x;
   logic signed [WORD_W-1:0] rsp_vel_y;
   logic signed [WORD_W-1:0] rsp_spin;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [WORD_W-1:0]        csr_wdata = '0;

   motion_request_type pending_requests[$];
   motion_state_type   expected_states[$];
   motion_request_type held_request;
   motion_state_type   model_state;
   logic [REG_W-1:0] drag_cfg [3];
   logic [REG_W-1:0] limit_cfg [3];
   int outstanding = 0;
   int fault_count = 0;
   bit calm = 1'b0;

   kinematic_motion_step_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_step_time(req_step_time),
      .req_accel_x(req_accel_x),
      .req_accel_y(req_accel_y),
      .req_accel_angular(req_accel_angular),
      .req_load_pos_x(req_load_pos_x),
      .req_load_pos_y(req_load_pos_y),
      .req_load_heading(req_load_heading),
      .req_load_vel_x(req_load_vel_x),
      .req_load_vel_y(req_load_vel_y),
      .req_load_spin(req_load_spin),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_heading(rsp_heading),
      .rsp_vel_x(rsp_vel_x),
      .rsp_vel_y(rsp_vel_y),
      .rsp_spin(rsp_spin),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(5_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic signed [WORD_W-1:0] clamp_word(input longint x);
      if (x > longint'(WORD_MAX)) begin
         return WORD_MAX;
      end else if (x < longint'(WORD_MIN)) begin
         return WORD_MIN;
      end
      return x[WORD_W-1:0];
   endfunction

   // returns {new position, new velocity}
   function automatic logic [2*WORD_W-1:0] advance_axis(
         input logic signed [WORD_W-1:0] pos, vel, acc,
         input logic [REG_W-1:0] drg, lim,
         input logic [DT_W-1:0] dt);
      longint v;
      longint t;
      longint mid;
      logic signed [WORD_W-1:0] new_pos;
      v = vel;
      if (acc != 0) begin
         v = clamp_word(v + ((longint'(acc) * longint'(dt) + 64'sd32768) >>> 16));
      end else if (drg != 0) begin
         t = (longint'(drg) * longint'(dt)) >>> 16;
         if (v - t > 0) begin
            v = v - t;
         end else if (v + t < 0) begin
            v = v + t;
         end else begin
            v = 0;
         end
      end
      if (v != 0 && lim != 0) begin
         if (v > longint'(lim)) begin
            v = longint'(lim);
         end else if (v < -longint'(lim)) begin
            v = -longint'(lim);
         end
      end
      mid = longint'(vel) + v;
      new_pos = clamp_word(longint'(pos) + ((mid * longint'(dt) + 64'sd65536) >>> 17));
      return {new_pos, v[WORD_W-1:0]};
   endfunction

   function automatic motion_state_type step_motion(input motion_request_type r);
      logic [2*WORD_W-1:0] pv;
      if (r.mode == MODE_LOAD) begin
         model_state.pos_x   = r.load_pos_x;
         model_state.pos_y   = r.load_pos_y;
         model_state.heading = r.load_heading;
         model_state.vel_x   = r.load_vel_x;
         model_state.vel_y   = r.load_vel_y;
         model_state.spin    = r.load_spin;
      end else begin
         pv = advance_axis(model_state.heading, model_state.spin, r.accel_angular,
                           drag_cfg[AXIS_ANG], limit_cfg[AXIS_ANG], r.step_time);
         model_state.heading = pv[2*WORD_W-1:WORD_W];
         model_state.spin    = pv[WORD_W-1:0];
         pv = advance_axis(model_state.pos_x, model_state.vel_x, r.accel_x,
                           drag_cfg[AXIS_X], limit_cfg[AXIS_X], r.step_time);
         model_state.pos_x = pv[2*WORD_W-1:WORD_W];
         model_state.vel_x = pv[WORD_W-1:0];
         pv = advance_axis(model_state.pos_y, model_state.vel_y, r.accel_y,
                           drag_cfg[AXIS_Y], limit_cfg[AXIS_Y], r.step_time);
         model_state.pos_y = pv[2*WORD_W-1:WORD_W];
         model_state.vel_y = pv[WORD_W-1:0];
      end
      return model_state;
   endfunction

   function automatic logic signed [WORD_W-1:0] pick_word();
      logic signed [WORD_W-1:0] w;
      case ($urandom_range(9))
         0: w = WORD_MAX;
         1: w = WORD_MIN;
         2: w = '0;
         3: begin
            w = $urandom_range(1, 16);
            if ($urandom_range(1)) w = -w;
         end
         4, 5: w = $urandom_range(32'h6_0000) - 32'h3_0000;
         default: w = $urandom();
      endcase
      return w;
   endfunction

   function automatic logic [DT_W-1:0] pick_step();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3, 4: return DT_W'($urandom_range(1, 16'h1000));
         default: return DT_W'($urandom());
      endcase
   endfunction

   function automatic logic signed [WORD_W-1:0] pick_accel();
      if ($urandom_range(99) < 35) return '0;
      return pick_word();
   endfunction

   function automatic logic [WORD_W-1:0] pick_reg();
      case ($urandom_range(5))
         0: return '0;
         1: return {1'b0, {REG_W{1'b1}}};
         2: return $urandom_range(1, 32'h4_0000);
         3: return $urandom_range(32'h1_0000, 32'h200_0000);
         default: return $urandom();
      endcase
   endfunction

   function automatic motion_request_type random_request();
      motion_request_type r;
      r.mode          = ($urandom_range(99) < 12) ? MODE_LOAD : MODE_ADVANCE;
      r.step_time     = pick_step();
      r.accel_x       = pick_accel();
      r.accel_y       = pick_accel();
      r.accel_angular = pick_accel();
      r.load_pos_x    = pick_word();
      r.load_pos_y    = pick_word();
      r.load_heading  = pick_word();
      r.load_vel_x    = pick_word();
      r.load_vel_y    = pick_word();
      r.load_spin     = pick_word();
      return r;
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_word(input string field, input logic [WORD_W-1:0] got, want);
      if (got !== want) note_fault($sformatf("%s got %h expected %h", field, got, want));
   endtask

   task automatic queue_request(input motion_request_type r);
      pending_requests.push_back(r);
      outstanding++;
   endtask

   task automatic queue_advance(input logic [DT_W-1:0] dt,
                                input logic signed [WORD_W-1:0] ax, ay, aa);
      motion_request_type r;
      r = random_request();
      r.mode = MODE_ADVANCE;
      r.step_time = dt;
      r.accel_x = ax;
      r.accel_y = ay;
      r.accel_angular = aa;
      queue_request(r);
   endtask

   task automatic queue_load(input logic signed [WORD_W-1:0] px, py, hd, vx, vy, sp);
      motion_request_type r;
      r = random_request();
      r.mode = MODE_LOAD;
      r.load_pos_x = px;
      r.load_pos_y = py;
      r.load_heading = hd;
      r.load_vel_x = vx;
      r.load_vel_y = vy;
      r.load_spin = sp;
      queue_request(r);
   endtask

   task automatic wait_idle();
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_DRAG_X:    drag_cfg[AXIS_X]    = data[REG_W-1:0];
         CSR_DRAG_Y:    drag_cfg[AXIS_Y]    = data[REG_W-1:0];
         CSR_DRAG_ANG:  drag_cfg[AXIS_ANG]  = data[REG_W-1:0];
         CSR_LIMIT_X:   limit_cfg[AXIS_X]   = data[REG_W-1:0];
         CSR_LIMIT_Y:   limit_cfg[AXIS_Y]   = data[REG_W-1:0];
         CSR_LIMIT_ANG: limit_cfg[AXIS_ANG] = data[REG_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : request_driver
      motion_request_type nxt;
      bit launch;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_states.push_back(step_motion(held_request));
         launch = (!req_valid || req_ready) && pending_requests.size() != 0
                  && (calm || $urandom_range(99) >= IDLE_PCT);
         if (launch) begin
            nxt = pending_requests.pop_front();
            held_request = nxt;
            req_mode          <= nxt.mode;
            req_step_time     <= nxt.step_time;
            req_accel_x       <= nxt.accel_x;
            req_accel_y       <= nxt.accel_y;
            req_accel_angular <= nxt.accel_angular;
            req_load_pos_x    <= nxt.load_pos_x;
            req_load_pos_y    <= nxt.load_pos_y;
            req_load_heading  <= nxt.load_heading;
            req_load_vel_x    <= nxt.load_vel_x;
            req_load_vel_y    <= nxt.load_vel_y;
            req_load_spin     <= nxt.load_spin;
            req_valid         <= 1'b1;
         end else if (req_ready) begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      motion_state_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_states.size() == 0) begin
               note_fault("response with no request outstanding");
            end else begin
               want = expected_states.pop_front();
               outstanding--;
               check_word("pos_x", rsp_pos_x, want.pos_x);
               check_word("pos_y", rsp_pos_y, want.pos_y);
               check_word("heading", rsp_heading, want.heading);
               check_word("vel_x", rsp_vel_x, want.vel_x);
               check_word("vel_y", rsp_vel_y, want.vel_y);
               check_word("spin", rsp_spin, want.spin);
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin : sequencer
      int count;
      int chunk;
      logic [WORD_W-1:0] reg_value;
      for (int a = 0; a < 3; a++) begin
         drag_cfg[a] = '0;
         limit_cfg[a] = '0;
      end
      model_state = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // registers at reset values: acceleration rounding and saturation
      queue_advance(16'h8000, 32'sh1_0000, -32'sh1_0000, 32'sd1);
      queue_advance(16'h0001, 32'sd1, -32'sh8000, 32'sh8000);
      queue_load(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, '0);
      queue_advance(16'hFFFF, WORD_MAX, WORD_MIN, WORD_MIN);
      queue_load(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX);
      queue_advance(16'hFFFF, WORD_MIN, WORD_MAX, WORD_MAX);
      queue_advance(16'h0000, WORD_MAX, WORD_MAX, WORD_MAX);
      queue_load('0, '0, '0, '0, '0, '0);
      wait_idle();

      // drag toward zero, limits, masked high bit, ignored indexes
      write_reg(CSR_DRAG_X, 32'h0002_0000);
      write_reg(CSR_DRAG_Y, 32'h7FFF_FFFF);
      write_reg(CSR_DRAG_ANG, 32'h0001_0000);
      write_reg(CSR_LIMIT_X, 32'h8005_0000);
      write_reg(CSR_LIMIT_Y, 32'h0000_0000);
      write_reg(CSR_LIMIT_ANG, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_A, $urandom());
      write_reg(CSR_SPARE_B, $urandom());
      queue_load(32'sh10_0000, -32'sh10_0000, 32'sh1234, 32'sh1_8000, -32'sh10_0000,
                 -32'sh8000);
      queue_advance(16'h8000, '0, '0, '0);
      queue_advance(16'hFFFF, '0, '0, '0);
      queue_load(WORD_MAX, WORD_MIN, '0, WORD_MAX, WORD_MIN, WORD_MIN);
      queue_advance(16'h0000, '0, '0, '0);
      queue_advance(16'h4000, WORD_MAX, WORD_MIN, WORD_MAX);
      queue_advance(16'hFFFF, WORD_MIN, '0, '0);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         calm = (phase == 2);
         for (int i = CSR_DRAG_X; i <= CSR_LIMIT_ANG; i++) begin
            if (phase == 1) begin
               reg_value = '1;
            end else if (phase == 3) begin
               reg_value = '0;
            end else begin
               reg_value = pick_reg();
            end
            write_reg(i[CSR_IDX_W-1:0], reg_value);
         end
         if ($urandom_range(2) == 0) write_reg(CSR_SPARE_A, $urandom());
         count = 0;
         while (count < PHASE_REQUESTS) begin
            chunk = $urandom_range(20, 60);
            if (chunk > PHASE_REQUESTS - count) chunk = PHASE_REQUESTS - count;
            repeat (chunk) queue_request(random_request());
            count += chunk;
            if ($urandom_range(3) == 0) wait_idle();
         end
         wait_idle();
      end
      calm = 1'b0;

      repeat (20) @(posedge clock);
      if (fault_count == 0 && expected_states.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
